// ===== hdl/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// shared constants, types and codes of the chained hash set
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int BUCKETS    = 7;
	localparam int NODES      = 64;
	localparam int VALUE_W    = 31;
	localparam int OPC_W      = 2;
	localparam int LINK_W     = $clog2(NODES + 1);
	localparam int NODE_AW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int MOD_BITS   = 8;
	localparam int MOD_CYCLES = (VALUE_W + MOD_BITS - 1) / MOD_BITS;
	localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
	localparam int VAL_PAD    = MOD_CYCLES * MOD_BITS;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_HEAD,
		S_WALK,
		S_FIX,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [LINK_W-1:0]  nxt;
		logic [VALUE_W-1:0] value;
	} node_t;

	typedef struct packed {
		logic               rd_en;
		logic [NODE_AW-1:0] rd_addr;
		logic               wr_en;
		logic [NODE_AW-1:0] wr_addr;
		node_t              wdata;
	} node_req_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [BKT_W-1:0]  addr;
		logic [LINK_W-1:0] wdata;
	} bkt_req_t;

endpackage

// ===== hdl/chs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// chs_mod_unit
// multi-cycle reduction of a value modulo the bucket count, one byte a cycle
// ----------------------------------------------------------------------------
module chs_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [chs_pkg::VALUE_W-1:0]   value,
	output logic                          done,
	output logic [chs_pkg::BKT_W-1:0]     rem
);
	import chs_pkg::*;

	localparam int REM2_W = BKT_W + 1;

	logic [VAL_PAD-1:0]   sh_q;
	logic [BKT_W-1:0]     rem_q;
	logic [BKT_W-1:0]     rem_d;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [BKT_W-1:0]     r;
	logic [REM2_W-1:0]    r2;

	always_comb begin
		r  = rem_q;
		r2 = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			r2 = {r, sh_q[VAL_PAD-1-i]};
			if (r2 >= REM2_W'(BUCKETS)) begin
				r2 = r2 - REM2_W'(BUCKETS);
			end
			r = r2[BKT_W-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(MOD_CYCLES - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= VAL_PAD'(value);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << MOD_BITS;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (REM2_W'(rem_q) < REM2_W'(BUCKETS)))
		else $error("bucket index out of range");

endmodule

// ===== hdl/chs_bucket_mem.sv =====
// ----------------------------------------------------------------------------
// chs_bucket_mem
// bucket head memory; per-bucket valid flags make every bucket empty at reset
// ----------------------------------------------------------------------------
module chs_bucket_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  chs_pkg::bkt_req_t           req,
	output logic [chs_pkg::LINK_W-1:0]  head
);
	import chs_pkg::*;

	logic [LINK_W-1:0]  bh_mem [BUCKETS];
	logic [BUCKETS-1:0] vld_q;
	logic [LINK_W-1:0]  rd_s1;
	logic               vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			bh_mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_s1 <= bh_mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= vld_q[req.addr];
			end
		end
	end

	assign head = vld_s1 ? rd_s1 : NIL_LINK;

endmodule

// ===== hdl/chs_node_mem.sv =====
// ----------------------------------------------------------------------------
// chs_node_mem
// node memory (link and value), one read and one write port; entries at or
// above the fill count read as linked to their successor
// ----------------------------------------------------------------------------
module chs_node_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  chs_pkg::node_req_t           req,
	output logic [chs_pkg::LINK_W-1:0]   rd_next,
	output logic [chs_pkg::VALUE_W-1:0]  rd_value
);
	import chs_pkg::*;

	node_t              nd_mem [NODES];
	node_t              rd_s1;
	logic [NODE_AW-1:0] raddr_s1;
	logic [LINK_W-1:0]  fresh_q;
	logic [LINK_W-1:0]  raddr_ext;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			nd_mem[req.wr_addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_s1    <= nd_mem[req.rd_addr];
			raddr_s1 <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
		end else if (req.wr_en && (LINK_W'(req.wr_addr) == fresh_q)) begin
			fresh_q <= fresh_q + 1'b1;
		end
	end

	assign raddr_ext = LINK_W'(raddr_s1);
	assign rd_next   = (raddr_ext >= fresh_q) ? raddr_ext + 1'b1 : rd_s1.nxt;
	assign rd_value  = rd_s1.value;

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr)))
		else $error("node read and write hit the same entry");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL_LINK)
		else $error("node fill count past pool size");

endmodule

// ===== hdl/chained_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set_core
// hash set with separate chaining over a fixed node pool and free list
// ----------------------------------------------------------------------------
// steps: modulo reduction, a bucket head read unless an insert finds the pool
// full or the opcode is unknown, a visit per chain node, and a fix-up step to
// unlink a node behind the head; throughput: one word at a time, set by the
// modulo reduction and the single read port of the node memory
// reset: arst_n empties all buckets through valid flags and rebuilds the free
// list through a fill count, so no clearing pass is needed
module chained_hash_set_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [chs_pkg::OPC_W-1:0]    opcode,
	input  logic [chs_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         pool_full
);
	import chs_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [OPC_W-1:0]   op_q;
	logic [VALUE_W-1:0] value_q;
	logic [BKT_W-1:0]   bkt_q;
	logic [LINK_W-1:0]  free_head_q;
	logic [LINK_W-1:0]  new_q;
	logic [LINK_W-1:0]  cur_q;
	logic [LINK_W-1:0]  cur_next_q;
	logic [LINK_W-1:0]  prev_q;
	logic [VALUE_W-1:0] prev_val_q;
	logic               res_hit_q;
	logic               res_full_q;
	logic               out_valid_q;
	logic               hit_q;
	logic               pool_full_q;

	logic               mod_start;
	logic               mod_done;
	logic [BKT_W-1:0]   mod_rem;
	node_req_t          nreq;
	bkt_req_t           breq;
	logic [LINK_W-1:0]  nd_next;
	logic [VALUE_W-1:0] nd_val;
	logic [LINK_W-1:0]  bh_head;

	logic               res_set;
	logic               res_hit_d;
	logic               res_full_d;
	logic               fh_ld;
	logic [LINK_W-1:0]  fh_d;
	logic               cur_ld;
	logic [LINK_W-1:0]  cur_d;
	logic               prev_clr;
	logic               prev_ld;
	logic               cur_next_ld;
	logic               out_ld;
	logic               nd_match;
	logic               nd_last;

	chs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (value),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	chs_bucket_mem u_bkt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (breq),
		.head   (bh_head)
	);

	chs_node_mem u_node (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (nreq),
		.rd_next  (nd_next),
		.rd_value (nd_val)
	);

	assign nd_match = (nd_val == value_q);
	assign nd_last  = (nd_next == NIL_LINK);
	assign in_stall = (state_q != S_IDLE);
	assign out_ld   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d     = state_q;
		mod_start   = 1'b0;
		nreq        = '0;
		breq        = '0;
		res_set     = 1'b0;
		res_hit_d   = 1'b0;
		res_full_d  = 1'b0;
		fh_ld       = 1'b0;
		fh_d        = nd_next;
		cur_ld      = 1'b0;
		cur_d       = nd_next;
		prev_clr    = 1'b0;
		prev_ld     = 1'b0;
		cur_next_ld = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mod_start = 1'b1;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					case (op_q)
						OP_INSERT: begin
							if (free_head_q == NIL_LINK) begin
								res_set    = 1'b1;
								res_full_d = 1'b1;
								state_d    = S_DONE;
							end else begin
								breq.rd_en   = 1'b1;
								breq.addr    = mod_rem;
								nreq.rd_en   = 1'b1;
								nreq.rd_addr = free_head_q[NODE_AW-1:0];
								state_d      = S_HEAD;
							end
						end
						OP_SEARCH, OP_DELETE: begin
							breq.rd_en = 1'b1;
							breq.addr  = mod_rem;
							state_d    = S_HEAD;
						end
						default: begin
							res_set = 1'b1;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_HEAD: begin
				if (op_q == OP_INSERT) begin
					// take the free node and fill it before linking
					fh_ld             = 1'b1;
					nreq.wr_en        = 1'b1;
					nreq.wr_addr      = free_head_q[NODE_AW-1:0];
					nreq.wdata.nxt    = NIL_LINK;
					nreq.wdata.value  = value_q;
					if (bh_head == NIL_LINK) begin
						breq.wr_en = 1'b1;
						breq.addr  = bkt_q;
						breq.wdata = free_head_q;
						res_set    = 1'b1;
						res_hit_d  = 1'b1;
						state_d    = S_DONE;
					end else begin
						nreq.rd_en   = 1'b1;
						nreq.rd_addr = bh_head[NODE_AW-1:0];
						cur_ld       = 1'b1;
						cur_d        = bh_head;
						state_d      = S_WALK;
					end
				end else if (bh_head == NIL_LINK) begin
					res_set = 1'b1;
					state_d = S_DONE;
				end else begin
					nreq.rd_en   = 1'b1;
					nreq.rd_addr = bh_head[NODE_AW-1:0];
					cur_ld       = 1'b1;
					cur_d        = bh_head;
					prev_clr     = 1'b1;
					state_d      = S_WALK;
				end
			end
			S_WALK: begin
				case (op_q)
					OP_INSERT: begin
						if (nd_last) begin
							nreq.wr_en       = 1'b1;
							nreq.wr_addr     = cur_q[NODE_AW-1:0];
							nreq.wdata.nxt   = new_q;
							nreq.wdata.value = nd_val;
							res_set          = 1'b1;
							res_hit_d        = 1'b1;
							state_d          = S_DONE;
						end else begin
							nreq.rd_en   = 1'b1;
							nreq.rd_addr = nd_next[NODE_AW-1:0];
							cur_ld       = 1'b1;
						end
					end
					OP_SEARCH: begin
						if (nd_match || nd_last) begin
							res_set   = 1'b1;
							res_hit_d = nd_match;
							state_d   = S_DONE;
						end else begin
							nreq.rd_en   = 1'b1;
							nreq.rd_addr = nd_next[NODE_AW-1:0];
							cur_ld       = 1'b1;
						end
					end
					OP_DELETE: begin
						if (nd_match) begin
							// push the node onto the free list
							nreq.wr_en       = 1'b1;
							nreq.wr_addr     = cur_q[NODE_AW-1:0];
							nreq.wdata.nxt   = free_head_q;
							nreq.wdata.value = nd_val;
							fh_ld            = 1'b1;
							fh_d             = cur_q;
							if (prev_q == NIL_LINK) begin
								breq.wr_en = 1'b1;
								breq.addr  = bkt_q;
								breq.wdata = nd_next;
								res_set    = 1'b1;
								res_hit_d  = 1'b1;
								state_d    = S_DONE;
							end else begin
								cur_next_ld = 1'b1;
								state_d     = S_FIX;
							end
						end else if (nd_last) begin
							res_set = 1'b1;
							state_d = S_DONE;
						end else begin
							nreq.rd_en   = 1'b1;
							nreq.rd_addr = nd_next[NODE_AW-1:0];
							cur_ld       = 1'b1;
							prev_ld      = 1'b1;
						end
					end
					default: begin
						res_set = 1'b1;
						state_d = S_DONE;
					end
				endcase
			end
			S_FIX: begin
				nreq.wr_en       = 1'b1;
				nreq.wr_addr     = prev_q[NODE_AW-1:0];
				nreq.wdata.nxt   = cur_next_q;
				nreq.wdata.value = prev_val_q;
				res_set          = 1'b1;
				res_hit_d        = 1'b1;
				state_d          = S_DONE;
			end
			S_DONE: begin
				if (out_ld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fh_ld) begin
				free_head_q <= fh_d;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mod_start) begin
			op_q    <= opcode;
			value_q <= value;
		end
		if (state_q == S_MOD && mod_done) begin
			bkt_q <= mod_rem;
		end
		if (state_q == S_HEAD) begin
			new_q <= free_head_q;
		end
		if (cur_ld) begin
			cur_q <= cur_d;
		end
		if (prev_clr) begin
			prev_q <= NIL_LINK;
		end else if (prev_ld) begin
			prev_q     <= cur_q;
			prev_val_q <= nd_val;
		end
		if (cur_next_ld) begin
			cur_next_q <= nd_next;
		end
		if (res_set) begin
			res_hit_q  <= res_hit_d;
			res_full_q <= res_full_d;
		end
		if (out_ld) begin
			hit_q       <= res_hit_q;
			pool_full_q <= res_full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign pool_full = pool_full_q;

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pool_full) |-> !hit)
		else $error("dropped insert reported as hit");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_DONE))
		else $error("result word raised outside the done state");

endmodule
